// ===== design/lst_pkg.sv =====
// lst_pkg: shared types, constants and arithmetic helpers for the lazy segment tree
// no dependencies; compiled first
package lst_pkg;

   localparam int LST_LEAVES  = 1024;
   localparam int LST_COUNT_W = 11;
   localparam int LST_MODE_W  = 3;
   localparam int LST_VALUE_W = 64;

   localparam logic [LST_COUNT_W-1:0] LST_COUNT_RESET = 11'd1024;
   // identity of max, -8e18
   localparam logic signed [LST_VALUE_W-1:0] LST_IDENTITY = 64'sh90FA_4A62_C4E0_0000;

   typedef enum logic [LST_MODE_W-1:0] {
      OP_SET  = 3'd0,
      OP_GET  = 3'd1,
      OP_RMAX = 3'd2,
      OP_RADD = 3'd3,
      OP_WMAX = 3'd4
   } lst_op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_PUSH_RD,
      ST_PUSH_LEFT,
      ST_PUSH_RIGHT,
      ST_PUSH_END,
      ST_LEAF,
      ST_LEAF_WAIT,
      ST_SCAN,
      ST_PULL_LEFT,
      ST_PULL_RIGHT,
      ST_PULL_WR,
      ST_DONE
   } lst_state_type;

   typedef struct packed {
      logic                          valid;
      logic signed [LST_VALUE_W-1:0] read_value;
      logic                          index_error;
   } lst_result_type;

   // saturating signed add
   function automatic logic signed [LST_VALUE_W-1:0] sat_add(
      input logic signed [LST_VALUE_W-1:0] x,
      input logic signed [LST_VALUE_W-1:0] y);
      logic signed [LST_VALUE_W:0] s;
      s = {x[LST_VALUE_W-1], x} + {y[LST_VALUE_W-1], y};
      if (s[LST_VALUE_W] != s[LST_VALUE_W-1]) begin
         return s[LST_VALUE_W] ? {1'b1, {(LST_VALUE_W-1){1'b0}}}
                               : {1'b0, {(LST_VALUE_W-1){1'b1}}};
      end
      return s[LST_VALUE_W-1:0];
   endfunction

   function automatic logic signed [LST_VALUE_W-1:0] max64(
      input logic signed [LST_VALUE_W-1:0] x,
      input logic signed [LST_VALUE_W-1:0] y);
      return (x > y) ? x : y;
   endfunction

endpackage

// ===== design/lst_channels.sv =====
// lst_channels: valid/ready interfaces for the request and response words
// depends on lst_pkg
interface lst_req_if;
   import lst_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [LST_MODE_W-1:0]         mode;
   logic [LST_COUNT_W-1:0]        left_index;
   logic [LST_COUNT_W-1:0]        right_index;
   logic signed [LST_VALUE_W-1:0] operand_value;

   modport source (output valid, mode, left_index, right_index, operand_value, input ready);
   modport sink (input valid, mode, left_index, right_index, operand_value, output ready);
endinterface

interface lst_rsp_if;
   import lst_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [LST_VALUE_W-1:0] read_value;
   logic                          index_error;

   modport source (output valid, read_value, index_error, input ready);
   modport sink (input valid, read_value, index_error, output ready);
endinterface

// ===== design/lst_ram.sv =====
// lst_ram: generic single write port, single read port ram with registered read
// no dependencies
module lst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== design/lst_ctrl.sv =====
// lst_ctrl: sequencer walking the tree in node and pending memories
// depends on lst_pkg and lst_channels
module lst_ctrl #(
   parameter int LEAVES = lst_pkg::LST_LEAVES
) (
   input  logic                                   clock,
   input  logic                                   reset,
   lst_req_if.sink                                req_chan,
   input  logic [lst_pkg::LST_COUNT_W-1:0]        leaf_count,
   input  logic                                   res_ready,
   output lst_pkg::lst_result_type                res,
   output logic                                   max_we,
   output logic [$clog2(LEAVES):0]                max_waddr,
   output logic signed [lst_pkg::LST_VALUE_W-1:0] max_wdata,
   output logic [$clog2(LEAVES):0]                max_raddr,
   input  logic signed [lst_pkg::LST_VALUE_W-1:0] max_rdata,
   output logic                                   pend_we,
   output logic [$clog2(LEAVES)-1:0]              pend_waddr,
   output logic signed [lst_pkg::LST_VALUE_W-1:0] pend_wdata,
   output logic [$clog2(LEAVES)-1:0]              pend_raddr,
   input  logic signed [lst_pkg::LST_VALUE_W-1:0] pend_rdata
);
   import lst_pkg::*;

   localparam int TLOG = $clog2(LEAVES);
   localparam int TS   = 1 << TLOG;
   localparam int KW   = TLOG;
   localparam int NW   = TLOG + 1;
   localparam int AW   = NW + 1;
   localparam int LW   = $clog2(TLOG + 1);
   localparam logic [LST_COUNT_W-1:0] LIM =
      (LEAVES > 2047) ? {LST_COUNT_W{1'b1}} : LST_COUNT_W'(LEAVES);
   localparam logic [AW-1:0] TS_A = AW'(TS);

   lst_state_type state_ff, state_in;
   lst_op_type    op_ff, op_in, req_op;
   logic          force_ff, force_in;
   logic          pull_ff, pull_in;
   logic          sel_ff, sel_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [AW-1:0] orig_a_ff, orig_a_in, orig_b_ff, orig_b_in;
   logic [KW-1:0] node_ff, node_in;
   logic [AW-1:0] ca_ff, ca_in, cb_ff, cb_in;
   logic          inflight_ff, inflight_in;
   logic [NW-1:0] scan_addr_ff, scan_addr_in;
   logic [NW-1:0] clr_cnt_ff, clr_cnt_in;
   logic signed [LST_VALUE_W-1:0] f_ff, f_in, tmp_ff, tmp_in, acc_ff, acc_in;
   logic signed [LST_VALUE_W-1:0] operand_ff, operand_in, result_ff, result_in;
   logic          error_ff, error_in;

   logic [LST_COUNT_W-1:0] used_n;
   logic          leaf_err, range_err, range_empty;
   logic [AW-1:0] walk_base, walk_shift, walk_mask;
   logic [KW-1:0] walk_node;
   logic          walk_cond, walk_last, walk_done;
   logic [NW-1:0] child_l, child_r;
   logic          scan_more, scan_issue, scan_end;
   logic [AW-1:0] scan_pick;
   logic [NW-1:0] scan_node;

   // request decode
   always_comb begin
      req_op      = lst_op_type'(req_chan.mode);
      used_n      = (leaf_count > LIM) ? LIM : leaf_count;
      leaf_err    = req_chan.left_index >= used_n;
      range_err   = (req_chan.left_index > req_chan.right_index)
                    || (req_chan.right_index > used_n);
      range_empty = req_chan.left_index == req_chan.right_index;
   end

   // ancestor walk: candidate node at the current level and side
   always_comb begin
      walk_base  = sel_ff ? (orig_b_ff - AW'(1)) : orig_a_ff;
      walk_shift = walk_base >> lvl_ff;
      walk_node  = walk_shift[KW-1:0];
      walk_mask  = ~({AW{1'b1}} << lvl_ff);
      walk_cond  = force_ff || (((sel_ff ? orig_b_ff : orig_a_ff) & walk_mask) != '0);
      walk_last  = force_ff || sel_ff;
      walk_done  = walk_last && (pull_ff ? (lvl_ff == LW'(TLOG)) : (lvl_ff == LW'(1)));
      child_l    = {node_ff, 1'b0};
      child_r    = {node_ff, 1'b1};
   end

   // range decomposition cursor
   always_comb begin
      scan_more  = ca_ff < cb_ff;
      scan_issue = scan_more && (ca_ff[0] || cb_ff[0]);
      scan_end   = !scan_more && !inflight_ff;
      scan_pick  = ca_ff[0] ? ca_ff : (cb_ff - AW'(1));
      scan_node  = scan_pick[NW-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               case (req_op)
                  OP_SET, OP_GET: state_in = leaf_err ? ST_DONE : ST_WALK;
                  OP_RMAX, OP_RADD:
                     state_in = (range_err || range_empty) ? ST_DONE : ST_WALK;
                  OP_WMAX: state_in = ST_LEAF;
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK: begin
            if (walk_cond) begin
               state_in = pull_ff ? ST_PULL_LEFT : ST_PUSH_RD;
            end else if (walk_done) begin
               if (pull_ff) state_in = ST_DONE;
               else if (op_ff == OP_SET || op_ff == OP_GET) state_in = ST_LEAF;
               else state_in = ST_SCAN;
            end
         end
         ST_PUSH_RD:    state_in = ST_PUSH_LEFT;
         ST_PUSH_LEFT:  state_in = ST_PUSH_RIGHT;
         ST_PUSH_RIGHT: state_in = ST_PUSH_END;
         ST_PUSH_END: begin
            if (!walk_done) state_in = ST_WALK;
            else if (op_ff == OP_SET || op_ff == OP_GET) state_in = ST_LEAF;
            else state_in = ST_SCAN;
         end
         ST_LEAF:      state_in = (op_ff == OP_SET) ? ST_WALK : ST_LEAF_WAIT;
         ST_LEAF_WAIT: state_in = ST_DONE;
         ST_SCAN: begin
            if (scan_end) state_in = (op_ff == OP_RMAX) ? ST_DONE : ST_WALK;
         end
         ST_PULL_LEFT:  state_in = ST_PULL_RIGHT;
         ST_PULL_RIGHT: state_in = ST_PULL_WR;
         ST_PULL_WR:    state_in = walk_done ? ST_DONE : ST_WALK;
         ST_DONE: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // handshake and result outputs
   always_comb begin
      req_chan.ready  = state_ff == ST_IDLE;
      res.valid       = (state_ff == ST_DONE) && res_ready;
      res.read_value  = result_ff;
      res.index_error = error_ff;
   end

   // memory ports
   always_comb begin
      max_we     = 1'b0;
      max_waddr  = '0;
      max_wdata  = '0;
      max_raddr  = '0;
      pend_we    = 1'b0;
      pend_waddr = '0;
      pend_wdata = '0;
      pend_raddr = '0;
      case (state_ff)
         ST_CLEAR: begin
            max_we     = 1'b1;
            max_waddr  = clr_cnt_ff;
            max_wdata  = LST_IDENTITY;
            pend_we    = !clr_cnt_ff[NW-1];
            pend_waddr = clr_cnt_ff[KW-1:0];
         end
         ST_PUSH_RD: pend_raddr = node_ff;
         ST_PUSH_LEFT: begin
            pend_we    = 1'b1;
            pend_waddr = node_ff;
            max_raddr  = child_l;
            pend_raddr = child_l[KW-1:0];
         end
         ST_PUSH_RIGHT: begin
            max_we     = 1'b1;
            max_waddr  = child_l;
            max_wdata  = sat_add(max_rdata, f_ff);
            pend_we    = !child_l[NW-1];
            pend_waddr = child_l[KW-1:0];
            pend_wdata = sat_add(pend_rdata, f_ff);
            max_raddr  = child_r;
            pend_raddr = child_r[KW-1:0];
         end
         ST_PUSH_END: begin
            max_we     = 1'b1;
            max_waddr  = child_r;
            max_wdata  = sat_add(max_rdata, f_ff);
            pend_we    = !child_r[NW-1];
            pend_waddr = child_r[KW-1:0];
            pend_wdata = sat_add(pend_rdata, f_ff);
         end
         ST_LEAF: begin
            max_raddr = orig_a_ff[NW-1:0];
            if (op_ff == OP_SET) begin
               max_we    = 1'b1;
               max_waddr = orig_a_ff[NW-1:0];
               max_wdata = operand_ff;
            end
         end
         ST_SCAN: begin
            max_raddr  = scan_node;
            pend_raddr = scan_node[KW-1:0];
            // add into the node read in the previous cycle
            if (inflight_ff && op_ff == OP_RADD) begin
               max_we     = 1'b1;
               max_waddr  = scan_addr_ff;
               max_wdata  = sat_add(max_rdata, operand_ff);
               pend_we    = !scan_addr_ff[NW-1];
               pend_waddr = scan_addr_ff[KW-1:0];
               pend_wdata = sat_add(pend_rdata, operand_ff);
            end
         end
         ST_PULL_LEFT:  max_raddr = child_l;
         ST_PULL_RIGHT: max_raddr = child_r;
         ST_PULL_WR: begin
            max_we    = 1'b1;
            max_waddr = NW'(node_ff);
            max_wdata = max64(tmp_ff, max_rdata);
         end
         default: ;
      endcase
   end

   // datapath register updates
   always_comb begin
      op_in        = op_ff;
      force_in     = force_ff;
      pull_in      = pull_ff;
      sel_in       = sel_ff;
      lvl_in       = lvl_ff;
      orig_a_in    = orig_a_ff;
      orig_b_in    = orig_b_ff;
      node_in      = node_ff;
      ca_in        = ca_ff;
      cb_in        = cb_ff;
      inflight_in  = 1'b0;
      scan_addr_in = scan_addr_ff;
      clr_cnt_in   = clr_cnt_ff;
      f_in         = f_ff;
      tmp_in       = tmp_ff;
      acc_in       = acc_ff;
      operand_in   = operand_ff;
      result_in    = result_ff;
      error_in     = error_ff;
      case (state_ff)
         ST_CLEAR: clr_cnt_in = clr_cnt_ff + NW'(1);
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in      = req_op;
               operand_in = req_chan.operand_value;
               result_in  = '0;
               error_in   = 1'b0;
               pull_in    = 1'b0;
               sel_in     = 1'b0;
               lvl_in     = LW'(TLOG);
               orig_a_in  = AW'(req_chan.left_index) + TS_A;
               orig_b_in  = AW'(req_chan.right_index) + TS_A;
               force_in   = (req_op == OP_SET) || (req_op == OP_GET);
               case (req_op)
                  OP_SET, OP_GET: error_in = leaf_err;
                  OP_RMAX, OP_RADD: begin
                     error_in = range_err;
                     if (!range_err && range_empty && req_op == OP_RMAX) begin
                        result_in = LST_IDENTITY;
                     end
                  end
                  OP_WMAX: orig_a_in = AW'(1);
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (walk_cond) begin
               node_in = walk_node;
            end else if (walk_done) begin
               ca_in  = orig_a_ff;
               cb_in  = orig_b_ff;
               acc_in = LST_IDENTITY;
            end else begin
               sel_in = !walk_last;
               if (walk_last) lvl_in = pull_ff ? (lvl_ff + LW'(1)) : (lvl_ff - LW'(1));
            end
         end
         ST_PUSH_LEFT: f_in = pend_rdata;
         ST_PUSH_END: begin
            if (walk_done) begin
               ca_in  = orig_a_ff;
               cb_in  = orig_b_ff;
               acc_in = LST_IDENTITY;
            end else begin
               sel_in = !walk_last;
               if (walk_last) lvl_in = lvl_ff - LW'(1);
            end
         end
         ST_LEAF: begin
            if (op_ff == OP_SET) begin
               pull_in = 1'b1;
               sel_in  = 1'b0;
               lvl_in  = LW'(1);
            end
         end
         ST_LEAF_WAIT: result_in = max_rdata;
         ST_SCAN: begin
            inflight_in  = scan_issue;
            scan_addr_in = scan_node;
            if (scan_more) begin
               if (ca_ff[0]) begin
                  ca_in = ca_ff + AW'(1);
               end else if (cb_ff[0]) begin
                  cb_in = cb_ff - AW'(1);
               end else begin
                  ca_in = ca_ff >> 1;
                  cb_in = cb_ff >> 1;
               end
            end
            if (inflight_ff && op_ff == OP_RMAX) acc_in = max64(acc_ff, max_rdata);
            if (scan_end) begin
               if (op_ff == OP_RMAX) begin
                  result_in = acc_ff;
               end else begin
                  pull_in = 1'b1;
                  sel_in  = 1'b0;
                  lvl_in  = LW'(1);
               end
            end
         end
         ST_PULL_RIGHT: tmp_in = max_rdata;
         ST_PULL_WR: begin
            if (!walk_done) begin
               sel_in = !walk_last;
               if (walk_last) lvl_in = lvl_ff + LW'(1);
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_cnt_ff  <= '0;
         inflight_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_cnt_ff  <= clr_cnt_in;
         inflight_ff <= inflight_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      force_ff     <= force_in;
      pull_ff      <= pull_in;
      sel_ff       <= sel_in;
      lvl_ff       <= lvl_in;
      orig_a_ff    <= orig_a_in;
      orig_b_ff    <= orig_b_in;
      node_ff      <= node_in;
      ca_ff        <= ca_in;
      cb_ff        <= cb_in;
      scan_addr_ff <= scan_addr_in;
      f_ff         <= f_in;
      tmp_ff       <= tmp_in;
      acc_ff       <= acc_in;
      operand_ff   <= operand_in;
      result_ff    <= result_in;
      error_ff     <= error_in;
   end

`ifndef SYNTHESIS
   // clearing pass covers every node before the first word is taken
   a_clear_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && state_in != ST_CLEAR) |-> clr_cnt_ff == '1)
      else $error("clearing pass ended early");

   // walk level stays inside the tree depth
   a_walk_level: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK |-> (lvl_ff >= LW'(1) && lvl_ff <= LW'(TLOG)))
      else $error("walk level out of range");

   // range cursor never runs past the leaf row end
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> cb_ff <= AW'(2 * TS))
      else $error("range cursor out of bounds");

   // a delivered result returns the sequencer to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      res.valid |=> state_ff == ST_IDLE)
      else $error("result without return to idle");
`endif
endmodule

// ===== design/lazy_segment_tree_add_max.sv =====
// Lazy segment tree with range add and range max over LEAVES signed 64-bit leaves.
// After reset a clearing pass over all 2*TS node addresses (TS = LEAVES rounded up to a
// power of two) fills the node memory with the max identity and zeroes the pending
// adds before the first word is taken. One request is in work at a time; all state
// sits in two single-port-per-direction memories (node maxima and pending adds), so
// each operation is a walk of memory accesses: an ancestor push reads the pending add
// and adds it into both children, a parent pull reads both children and writes their
// max back, ancestors that need neither are skipped, and the range decomposition
// visits the nodes of each level in turn. A range max has no pulls. A finished result
// sits in an output register so the next request is taken while it waits.
// depends on lst_pkg, lst_channels, lst_ram, lst_ctrl
module lazy_segment_tree_add_max #(
   parameter int LEAVES = lst_pkg::LST_LEAVES
) (
   input  logic                            clock,
   input  logic                            reset,
   lst_req_if.sink                         req_chan,
   lst_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [lst_pkg::LST_COUNT_W-1:0] csr_write_data
);
   import lst_pkg::*;

   localparam int TLOG = $clog2(LEAVES);
   localparam int TS   = 1 << TLOG;

   logic [LST_COUNT_W-1:0] leaf_count_ff, leaf_count_in;
   lst_result_type         res;
   logic                   res_ready;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [LST_VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_error_ff, rsp_error_in;

   logic                          max_we, pend_we;
   logic [TLOG:0]                 max_waddr, max_raddr;
   logic [TLOG-1:0]               pend_waddr, pend_raddr;
   logic signed [LST_VALUE_W-1:0] max_wdata, max_rdata, pend_wdata, pend_rdata;

   lst_ctrl #(.LEAVES(LEAVES)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .leaf_count (leaf_count_ff),
      .res_ready  (res_ready),
      .res        (res),
      .max_we     (max_we),
      .max_waddr  (max_waddr),
      .max_wdata  (max_wdata),
      .max_raddr  (max_raddr),
      .max_rdata  (max_rdata),
      .pend_we    (pend_we),
      .pend_waddr (pend_waddr),
      .pend_wdata (pend_wdata),
      .pend_raddr (pend_raddr),
      .pend_rdata (pend_rdata)
   );

   lst_ram #(.WIDTH(LST_VALUE_W), .DEPTH(2 * TS)) u_max_ram (
      .clock (clock),
      .we    (max_we),
      .waddr (max_waddr),
      .wdata (max_wdata),
      .raddr (max_raddr),
      .rdata (max_rdata)
   );

   lst_ram #(.WIDTH(LST_VALUE_W), .DEPTH(TS)) u_pend_ram (
      .clock (clock),
      .we    (pend_we),
      .waddr (pend_waddr),
      .wdata (pend_wdata),
      .raddr (pend_raddr),
      .rdata (pend_rdata)
   );

   // leaf count register
   always_comb begin
      leaf_count_in = csr_write_enable ? csr_write_data : leaf_count_ff;
   end

   // output word register
   always_comb begin
      res_ready    = !rsp_valid_ff || rsp_chan.ready;
      rsp_valid_in = res.valid || (rsp_valid_ff && !rsp_chan.ready);
      rsp_value_in = res.valid ? res.read_value : rsp_value_ff;
      rsp_error_in = res.valid ? res.index_error : rsp_error_ff;
      rsp_chan.valid       = rsp_valid_ff;
      rsp_chan.read_value  = rsp_value_ff;
      rsp_chan.index_error = rsp_error_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= LST_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         leaf_count_ff <= leaf_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end
endmodule

// ===== bench/tb_channels_note.sv =====
// tb_channels_note: bench-side scoreboard types for the segment tree bench
// depends on lst_pkg; the valid/ready interfaces come from design/lst_channels.sv
package tb_lst_types;
   import lst_pkg::*;

   typedef struct {
      logic signed [LST_VALUE_W-1:0] read_value;
      logic                          index_error;
   } tree_answer_type;
endpackage

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for lazy_segment_tree_add_max
// drives request words, predicts each response with a behavioral segment tree
// depends on lst_pkg, lst_channels, tb_lst_types and the block's rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lst_pkg::*;
   import tb_lst_types::*;

   localparam int TS = 1024;
   localparam int TLOG = 10;
   localparam logic signed [63:0] VMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] VMIN = 64'sh8000_0000_0000_0000;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [LST_COUNT_W-1:0] csr_write_data = '0;

   lst_req_if req_chan ();
   lst_rsp_if rsp_chan ();

   lazy_segment_tree_add_max dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data));

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // predicted tree state
   logic signed [63:0] node_max [2*TS];
   logic signed [63:0] lazy_add [TS];
   int unsigned leaf_limit;
   tree_answer_type answers_due [$];
   int mismatch_count = 0;
   bit stall_enable = 1;
   bit hold_off = 0;

   function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? VMIN : VMAX;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] bigger(logic signed [63:0] a, logic signed [63:0] b);
      return a > b ? a : b;
   endfunction

   function automatic void apply_add(int k, logic signed [63:0] f);
      node_max[k] = add_sat(node_max[k], f);
      if (k < TS) lazy_add[k] = add_sat(lazy_add[k], f);
   endfunction

   function automatic void push_node(int k);
      apply_add(2*k, lazy_add[k]);
      apply_add(2*k+1, lazy_add[k]);
      lazy_add[k] = 0;
   endfunction

   function automatic void pull_node(int k);
      node_max[k] = bigger(node_max[2*k], node_max[2*k+1]);
   endfunction

   function automatic void tree_clear();
      foreach (node_max[i]) node_max[i] = LST_IDENTITY;
      foreach (lazy_add[i]) lazy_add[i] = 0;
      leaf_limit = 1024;
   endfunction

   // predicted response to one request word
   function automatic tree_answer_type tree_predict(logic [2:0] mode, int unsigned l,
         int unsigned r, logic signed [63:0] v);
      tree_answer_type ans;
      int unsigned n, p, a, b, a0, b0;
      logic signed [63:0] ml, mr;
      ans.read_value = 0;
      ans.index_error = 0;
      n = leaf_limit > TS ? TS : leaf_limit;
      if (mode == OP_SET || mode == OP_GET) begin
         if (l >= n) ans.index_error = 1;
         else begin
            p = l + TS;
            for (int i = TLOG; i >= 1; i--) push_node(p >> i);
            if (mode == OP_SET) begin
               node_max[p] = v;
               for (int i = 1; i <= TLOG; i++) pull_node(p >> i);
            end else ans.read_value = node_max[p];
         end
      end else if (mode == OP_RMAX || mode == OP_RADD) begin
         if (l > r || r > n) ans.index_error = 1;
         else if (l == r) begin
            if (mode == OP_RMAX) ans.read_value = LST_IDENTITY;
         end else begin
            a = l + TS;
            b = r + TS;
            for (int i = TLOG; i >= 1; i--) begin
               if (((a >> i) << i) != a) push_node(a >> i);
               if (((b >> i) << i) != b) push_node((b - 1) >> i);
            end
            if (mode == OP_RMAX) begin
               ml = LST_IDENTITY;
               mr = LST_IDENTITY;
               while (a < b) begin
                  if (a & 1) begin ml = bigger(ml, node_max[a]); a++; end
                  if (b & 1) begin b--; mr = bigger(node_max[b], mr); end
                  a >>= 1;
                  b >>= 1;
               end
               ans.read_value = bigger(ml, mr);
            end else begin
               a0 = a;
               b0 = b;
               while (a < b) begin
                  if (a & 1) begin apply_add(a, v); a++; end
                  if (b & 1) begin b--; apply_add(b, v); end
                  a >>= 1;
                  b >>= 1;
               end
               for (int i = 1; i <= TLOG; i++) begin
                  if (((a0 >> i) << i) != a0) pull_node(a0 >> i);
                  if (((b0 >> i) << i) != b0) pull_node((b0 - 1) >> i);
               end
            end
         end
      end else if (mode == OP_WMAX) ans.read_value = node_max[1];
      return ans;
   endfunction

   // send one request word and record its expected response
   task automatic send_word(logic [2:0] mode, logic [10:0] l, logic [10:0] r,
         logic signed [63:0] v);
      int gap;
      if (stall_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 19);
         req_chan.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1;
      req_chan.mode <= mode;
      req_chan.left_index <= l;
      req_chan.right_index <= r;
      req_chan.operand_value <= v;
      do @(posedge clock); while (!req_chan.ready);
      answers_due.push_back(tree_predict(mode, l, r, v));
   endtask

   // wait until every response is back plus latency slack
   task automatic drain_all();
      req_chan.valid <= 0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_leaf_count(logic [10:0] cnt);
      drain_all();
      csr_write_enable <= 1;
      csr_write_data <= cnt;
      @(posedge clock);
      csr_write_enable <= 0;
      leaf_limit = cnt;
   endtask

   function automatic logic signed [63:0] pick_value();
      case ($urandom_range(0, 5))
         0: return VMAX;
         1: return VMIN;
         2: return $signed({$urandom, $urandom});
         default: return $signed(64'($urandom_range(0, 2000)) - 64'sd1000);
      endcase
   endfunction

   task automatic random_words(int count, int unsigned span);
      int unsigned l, r;
      logic [2:0] m;
      for (int k = 0; k < count; k++) begin
         m = 3'($urandom_range(0, 7));
         if (m > 4 && $urandom_range(0, 3) != 0) m = OP_RADD;
         l = $urandom_range(0, span);
         r = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047)
                                       : l + $urandom_range(0, span - l + 1);
         if ($urandom_range(0, 15) == 0) l = $urandom_range(0, 2047);
         send_word(m, 11'(l), 11'(r), pick_value());
      end
   endtask

   // extremes, every mode, error and empty cases
   task automatic test_directed();
      send_word(OP_WMAX, 0, 0, 0);
      send_word(OP_GET, 5, 0, 0);
      send_word(OP_SET, 0, 0, VMAX);
      send_word(OP_SET, 1023, 0, VMIN);
      send_word(OP_SET, 1024, 0, 7);
      send_word(OP_GET, 2047, 0, 0);
      send_word(OP_RADD, 0, 1024, VMAX);
      send_word(OP_RMAX, 0, 1024, 0);
      send_word(OP_RADD, 0, 1024, VMIN);
      send_word(OP_RADD, 0, 1024, VMIN);
      send_word(OP_GET, 0, 0, 0);
      send_word(OP_RMAX, 3, 3, 0);
      send_word(OP_RADD, 3, 3, 99);
      send_word(OP_RMAX, 9, 4, 0);
      send_word(OP_RADD, 0, 1025, 1);
      send_word(OP_RMAX, 2047, 2047, 0);
      send_word(3'd5, 0, 0, 0);
      send_word(3'd7, 2047, 2047, -1);
      send_word(OP_RMAX, 1, 1023, 0);
      send_word(OP_WMAX, 0, 0, 0);
   endtask

   // long receiver hold-off so the block backs up
   task automatic test_backpressure();
      hold_off = 1;
      for (int k = 0; k < 8; k++) send_word(OP_GET, k, 0, 0);
      hold_off = 0;
      drain_all();
   endtask

   task automatic test_leaf_counts();
      write_leaf_count(1);
      send_word(OP_SET, 0, 0, 42);
      send_word(OP_GET, 1, 0, 0);
      send_word(OP_RMAX, 0, 1, 0);
      random_words(30, 1);
      write_leaf_count(13);
      random_words(120, 13);
      write_leaf_count(2047);
      random_words(40, 1024);
      write_leaf_count(1024);
      random_words(150, 40);
      write_leaf_count(300);
      random_words(100, 300);
   endtask

   task automatic test_unstalled();
      stall_enable = 0;
      write_leaf_count(1024);
      random_words(80, 1024);
   endtask

   // response checker with random stalls
   always @(posedge clock) begin
      tree_answer_type exp_ans;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (answers_due.size() == 0) begin
            $display("%0t: unexpected response %0d err %0b", $realtime,
                     rsp_chan.read_value, rsp_chan.index_error);
            mismatch_count++;
         end else begin
            exp_ans = answers_due.pop_front();
            if (exp_ans.read_value !== rsp_chan.read_value) begin
               $display("%0t: read_value expected %0d got %0d", $realtime,
                        exp_ans.read_value, rsp_chan.read_value);
               mismatch_count++;
            end
            if (exp_ans.index_error !== rsp_chan.index_error) begin
               $display("%0t: index_error expected %0b got %0b", $realtime,
                        exp_ans.index_error, rsp_chan.index_error);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int burst;
      burst = 0;
      rsp_chan.ready = 0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_chan.ready <= 0;
            repeat (400) @(posedge clock);
         end
         if (burst > 0) begin
            burst--;
            rsp_chan.ready <= 0;
         end else if (stall_enable && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 19) - 1;
            rsp_chan.ready <= 0;
         end else rsp_chan.ready <= 1;
      end
   end

   initial begin
      req_chan.valid = 0;
      req_chan.mode = '0;
      req_chan.left_index = '0;
      req_chan.right_index = '0;
      req_chan.operand_value = '0;
      tree_clear();
      repeat (10) @(posedge clock);
      reset <= 0;
      test_directed();
      test_backpressure();
      test_leaf_counts();
      test_unstalled();
      drain_all();
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end
endmodule
